/* hw/rtl/case_insensitive_adler_checksum_defines.svh */
// assertion macros for the case-insensitive adler checksum block
`ifndef CASE_INSENSITIVE_ADLER_CHECKSUM_DEFINES_SVH
`define CASE_INSENSITIVE_ADLER_CHECKSUM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cia_pkg.sv */
// shared types, constants and helper functions for the adler checksum block
package cia_pkg;

  // adler modulus, one bit wider than the sums so a raw sum compares directly
  localparam logic [16:0] CIA_ADLER_MOD = 17'd65521;

  // default depth of the queue between front and back
  localparam int CIA_QUEUE_DEPTH = 4;

  // ascii range that gets folded to lower case
  localparam logic [7:0] CIA_UPPER_FIRST = 8'h41;
  localparam logic [7:0] CIA_UPPER_LAST  = 8'h5A;
  localparam logic [7:0] CIA_CASE_OFFSET = 8'h20;

  // one classified item as it sits in the queue
  typedef struct packed {
    logic       last;
    logic       valid;
    logic [7:0] chr;
  } cia_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } cia_qstat_t;

  function automatic logic [7:0] fold_lower(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if ((b >= CIA_UPPER_FIRST) && (b <= CIA_UPPER_LAST)) begin
      r = b + CIA_CASE_OFFSET;
    end
    return r;
  endfunction

  // both operands below the modulus, so one conditional subtract suffices
  function automatic logic [15:0] add_mod(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CIA_ADLER_MOD) begin
      s = s - CIA_ADLER_MOD;
    end
    return s[15:0];
  endfunction

endpackage

/* hw/rtl/case_insensitive_adler_checksum.sv */
// top level of the case-insensitive adler checksum block
// Case-insensitive Adler-style string checksum. Bytes stream in on the in_
// channel, one byte per transaction, with in_tuser marking a real character
// and in_tlast marking the end of a string; upper-case ASCII letters are
// folded to lower case before summing. Both sums start at zero (unlike plain
// adler32), are kept modulo 65521, and on the ending transaction the block
// returns {high_sum, low_sum} on out_tdata and clears both sums, so an ending
// transaction with no character on fresh sums gives zero. Transactions with
// neither a character nor an end mark are taken and ignored. The block takes
// one transaction per cycle while the queue is not full; that rate rests on
// the back end's two chained add-and-subtract-modulus steps being combinational.
// The result's out_tvalid comes from the result register: the ending item is
// first written into a queue slot, then the back end pops it and loads the
// result register. Only a stalled result register holds the back end, and
// then only at an ending transaction; the queue of QUEUE_DEPTH entries keeps
// the input side running meanwhile, until it fills.
`include "case_insensitive_adler_checksum_defines.svh"

module case_insensitive_adler_checksum
  import cia_pkg::*;
#(
  parameter int QUEUE_DEPTH = CIA_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // [0] char_valid
  input  logic        in_tlast,   // end_of_string
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] hash_value
);

  cia_qstat_t q_stat;
  cia_item_t  push_item;
  cia_item_t  head;
  logic       push;
  logic       pop;

  // front: classify and fold, drop transactions that carry nothing
  cia_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue between the two halves
  cia_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: running sums and registered result
  cia_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // both halves of a result are reduced sums
  `CIA_ASSERT_NOW(a_sums_reduced, out_tvalid, ((out_tdata[15:0] < CIA_ADLER_MOD[15:0]) && (out_tdata[31:16] < CIA_ADLER_MOD[15:0])), "result sum not reduced")
  // an ending item never overwrites a result that is still waiting
  `CIA_ASSERT_NOW(a_no_overwrite, (pop && head.last), (!out_tvalid || out_tready), "pending result overwritten")
  // a new result only follows an ending item leaving the queue
  `CIA_ASSERT_NEXT(a_result_source, (!out_tvalid || out_tready) && !(pop && head.last), !out_tvalid, "result without ending item")
  // the back end only takes from a queue that holds something
  `CIA_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule

/* hw/rtl/cia_front.sv */
// front end: accepts input transactions, folds case and drops idle items
module cia_front
  import cia_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       in_tlast,
  input  cia_qstat_t q_stat,
  output logic       push,
  output cia_item_t  push_item
);

  assign in_tready = !q_stat.full;

  // an item with no character and no end mark changes nothing
  assign push = in_tvalid && in_tready && (in_tuser || in_tlast);

  always_comb begin
    push_item.last  = in_tlast;
    push_item.valid = in_tuser;
    push_item.chr   = fold_lower(in_tdata);
  end

endmodule

/* hw/rtl/cia_queue.sv */
// short first-in first-out queue between front and back
module cia_queue
  import cia_pkg::*;
#(
  parameter int QUEUE_DEPTH = CIA_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cia_item_t  push_item,
  input  logic       pop,
  output cia_item_t  head,
  output cia_qstat_t q_stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cia_item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

/* hw/rtl/cia_back.sv */
// back end: running adler sums and the registered result stage
module cia_back
  import cia_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cia_item_t   head,
  input  cia_qstat_t  q_stat,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  logic [15:0] low_r, low_nxt;
  logic [15:0] high_r, high_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [15:0] low_sum;
  logic [15:0] high_sum;

  // an ending item needs a free result register, other items always go
  assign pop = !q_stat.empty && (!head.last || !out_valid_r || out_tready);

  always_comb begin
    low_sum  = low_r;
    high_sum = high_r;
    if (head.valid) begin
      low_sum  = add_mod(low_r, {8'h00, head.chr});
      high_sum = add_mod(high_r, low_sum);
    end
    low_nxt  = head.last ? 16'h0000 : low_sum;
    high_nxt = head.last ? 16'h0000 : high_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
      end
      if (pop && head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data_r <= {high_sum, low_sum};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* tb/case_insensitive_adler_checksum_tb.sv */
// testbench for the case-insensitive adler checksum block: directed table, then random strings
module case_insensitive_adler_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // adler modulus and folding range, kept locally for the predictor
  localparam logic [16:0] ADLER_MODULUS = 17'd65521;
  localparam logic [7:0]  UPPER_A       = 8'h41;
  localparam logic [7:0]  UPPER_Z       = 8'h5A;
  localparam logic [7:0]  CASE_SHIFT    = 8'h20;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 650;
  // a result passes a queue slot and the result register after its ending transaction; margin on top
  localparam int SETTLE_CYCLES = 8;
  // worst case per item is roughly a long send gap plus a long receive stall
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] char_byte
  logic        in_tuser   = 1'b0;    // [0] char_valid
  logic        in_tlast   = 1'b0;    // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [31:0] hash_value

  case_insensitive_adler_checksum DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: running sums and the queue of hashes still to come out
  // ---------------------------------------------------------------------------
  logic [15:0] run_low  = 16'h0000;
  logic [15:0] run_high = 16'h0000;
  logic [31:0] pending_hashes[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  // only 'A'..'Z' move, everything else (high bytes too) passes through
  function automatic logic [7:0] to_lower_ascii(logic [7:0] chr);
    if (chr >= UPPER_A && chr <= UPPER_Z) begin
      return chr + CASE_SHIFT;
    end
    return chr;
  endfunction

  // both operands are below the modulus, so one subtract brings it back
  function automatic logic [15:0] mod_accumulate(logic [15:0] acc, logic [15:0] addend);
    logic [16:0] total;
    total = {1'b0, acc} + {1'b0, addend};
    if (total >= ADLER_MODULUS) begin
      total = total - ADLER_MODULUS;
    end
    return total[15:0];
  endfunction

  // advance the sums by one accepted transaction; returns the hash for an ending one
  function automatic logic [31:0] advance_sums(logic [7:0] chr, logic valid, logic last);
    logic [31:0] hash;
    hash = 32'h0;
    if (valid) begin
      run_low  = mod_accumulate(run_low, {8'h00, to_lower_ascii(chr)});
      run_high = mod_accumulate(run_high, run_low);
    end
    if (last) begin
      hash     = {run_high, run_low};
      run_low  = 16'h0000;
      run_high = 16'h0000;
    end
    return hash;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at cycle %0d: %s, expected %08h got %08h",
             cycle_count, what, want, got);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // bytes weighted toward the folding boundaries and the extremes
  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'($urandom_range(UPPER_A, UPPER_Z));
    if (r < 50) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 60) begin
      case ($urandom_range(3))
        0:       return 8'h40;
        1:       return 8'h5B;
        2:       return 8'h60;
        default: return 8'h7B;
      endcase
    end
    if (r < 65) return 8'h00;
    if (r < 70) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // input side driver
  // ---------------------------------------------------------------------------
  // known = 1 means the table row carries its own expected hash
  task automatic push_char(input logic [7:0] chr, input logic valid, input logic last,
                           input logic known, input logic [31:0] known_hash,
                           input int gap);
    logic [31:0] hash;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= chr;
    in_tuser  <= valid;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transaction taken at this edge
    hash = advance_sums(chr, valid, last);
    if (last) begin
      pending_hashes.push_back(known ? known_hash : hash);
    end
  endtask

  // hold the sender off until every hash has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure with occasional steady stretches
  // ---------------------------------------------------------------------------
  int stall_left  = 0;
  int steady_left = 0;

  always @(posedge clk) begin
    if (steady_left > 0) begin
      steady_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(99) < 4) begin
        steady_left = $urandom_range(20, 80);
      end else if ($urandom_range(99) < 30) begin
        stall_left = gap_length();
      end
    end
  end

  // compare each result transaction with the oldest expected hash
  logic [31:0] want_hash;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("result with nothing expected", 32'h0, out_tdata);
      end else begin
        want_hash = pending_hashes.pop_front();
        if (out_tdata !== want_hash) begin
          report_mismatch("hash_value", want_hash, out_tdata);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table: char, char_valid, end, hash typed in, hash
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]  chr;
    logic        valid;
    logic        last;
    logic        known;
    logic [31:0] hash;
  } dir_row_t;

  localparam int DIRECTED_ROWS = 23;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000},  // empty string straight after reset
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'h0},          // idle item, ignored
    '{8'h5A, 1'b0, 1'b1, 1'b1, 32'h0000_0000},  // empty end, byte not folded in
    '{8'h41, 1'b1, 1'b1, 1'b1, 32'h0061_0061},  // 'A' folds to 'a'
    '{8'h5A, 1'b1, 1'b1, 1'b1, 32'h007A_007A},  // 'Z' folds to 'z'
    '{8'h40, 1'b1, 1'b1, 1'b1, 32'h0040_0040},  // just below the range
    '{8'h5B, 1'b1, 1'b1, 1'b1, 32'h005B_005B},  // just above the range
    '{8'h60, 1'b1, 1'b1, 1'b1, 32'h0060_0060},
    '{8'h7B, 1'b1, 1'b1, 1'b1, 32'h007B_007B},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 32'h00FF_00FF},  // largest byte, unsigned
    '{8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000},  // lone zero byte
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},          // zero bytes are not terminators
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h48, 1'b1, 1'b0, 1'b0, 32'h0},          // 'H', with an idle item next inside the string
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h69, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},          // end carrying no character
    '{8'h41, 1'b1, 1'b0, 1'b0, 32'h0},          // mixed case
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h43, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h2E, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 32'h0080_0080}   // top bit set, no folding
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          sent;
    int          string_count;
    int          str_len;
    bit          long_run;
    bit          quiet;
    logic [7:0]  chr;

    sent         = 0;
    string_count = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      push_char(directed_rows[i].chr, directed_rows[i].valid, directed_rows[i].last,
                directed_rows[i].known, directed_rows[i].hash, gap_length());
    end

    // let everything out before the random strings start
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      // long runs of 0xFF push the low sum past the modulus
      long_run = (string_count == 2) || ($urandom_range(199) == 0);
      str_len  = long_run ? $urandom_range(257, 300) : $urandom_range(0, 12);
      quiet    = ($urandom_range(3) == 0);
      for (int k = 0; k < str_len; k++) begin
        if ($urandom_range(19) == 0) begin
          // noise: idle transaction, not counted
          push_char(8'($urandom), 1'b0, 1'b0, 1'b0, 32'h0, quiet ? 0 : gap_length());
        end
        if (long_run && $urandom_range(9) != 0) begin
          chr = 8'hFF;
        end else begin
          chr = random_char();
        end
        push_char(chr, 1'b1, 1'b0, 1'b0, 32'h0, quiet ? 0 : gap_length());
        sent++;
      end
      // ending transaction, sometimes without a character
      if ($urandom_range(4) == 0) begin
        push_char(8'($urandom), 1'b0, 1'b1, 1'b0, 32'h0, quiet ? 0 : gap_length());
      end else begin
        push_char(random_char(), 1'b1, 1'b1, 1'b0, 32'h0, quiet ? 0 : gap_length());
      end
      sent++;
      string_count++;
      if ($urandom_range(29) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
